FILE: src/ninv_pkg.sv
// ----------------------------------------------------------------------------
// ninv_pkg: shared types and constants of the normal-matrix unit
// Holds the sideband struct that travels with each beat through the divider
// chain, the register reset value and the tuser bit positions.
// ----------------------------------------------------------------------------
package ninv_pkg;

  // Number of matrix entries in one beat.
  localparam int unsigned NumEntries = 9;

  // Singular threshold register.
  localparam int unsigned EpsWidth = 40;
  localparam logic [EpsWidth-1:0] EpsReset = 40'd281474977;

  // Bit positions inside the result tuser.
  localparam int unsigned UserSingular  = 0;
  localparam int unsigned UserSaturated = 1;
  localparam int unsigned UserWidth     = 2;

  // Per-beat sideband: result sign of each entry and the singular decision.
  typedef struct packed {
    logic [NumEntries-1:0] neg;
    logic                  singular;
  } ninv_side_t;

endpackage

FILE: src/ninv_front.sv
// ----------------------------------------------------------------------------
// ninv_front: cofactor and determinant pipeline
// Five registered stages: cofactor products, cofactors, determinant partial
// products, determinant, then division operands and the singular decision.
// ----------------------------------------------------------------------------
module ninv_front
  import ninv_pkg::*;
#(
  parameter int unsigned ENTRY_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned RW          = 134,
  parameter int unsigned DW          = 99
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [ENTRY_WIDTH-1:0] w_i [NumEntries],
  input  logic [EpsWidth-1:0]           eps_i,
  output logic                          valid_o,
  output logic [RW-1:0]                 rem_o [NumEntries],
  output logic [DW:0]                   den_o,
  output ninv_side_t                    side_o
);

  localparam int unsigned E  = ENTRY_WIDTH;
  localparam int unsigned PW = 2 * E;
  localparam int unsigned CW = 2 * E + 1;

  logic [4:0] vld_q;

  logic signed [E-1:0]  a [3][3];
  logic signed [PW-1:0] p0_q [NumEntries];
  logic signed [PW-1:0] p1_q [NumEntries];
  logic signed [CW-1:0] c2_q [NumEntries];
  logic signed [CW-1:0] c3_q [NumEntries];
  logic signed [CW-1:0] c4_q [NumEntries];
  logic signed [E-1:0]  a0_1_q [3];
  logic signed [E-1:0]  a0_2_q [3];
  logic signed [CW-1:0] pl_q [3];
  logic signed [CW-1:0] ph_q [3];
  logic signed [DW-1:0] det_q;
  logic [DW-1:0]        dmag;
  logic [RW-1:0]        rem_q [NumEntries];
  logic [DW:0]          den_q;
  ninv_side_t           side_q;

  // A is the transpose of the world matrix.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a[i][j] = w_i[j*3 + i];
      end
    end
  end

  // Valid bits of the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Stage 1: the two products of every 2x2 minor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q[0] <= a[1][1] * a[2][2];  p1_q[0] <= a[1][2] * a[2][1];
      p0_q[1] <= a[0][2] * a[2][1];  p1_q[1] <= a[0][1] * a[2][2];
      p0_q[2] <= a[0][1] * a[1][2];  p1_q[2] <= a[0][2] * a[1][1];
      p0_q[3] <= a[1][2] * a[2][0];  p1_q[3] <= a[1][0] * a[2][2];
      p0_q[4] <= a[0][0] * a[2][2];  p1_q[4] <= a[0][2] * a[2][0];
      p0_q[5] <= a[0][2] * a[1][0];  p1_q[5] <= a[0][0] * a[1][2];
      p0_q[6] <= a[1][0] * a[2][1];  p1_q[6] <= a[1][1] * a[2][0];
      p0_q[7] <= a[0][1] * a[2][0];  p1_q[7] <= a[0][0] * a[2][1];
      p0_q[8] <= a[0][0] * a[1][1];  p1_q[8] <= a[0][1] * a[1][0];
      for (int j = 0; j < 3; j++) begin
        a0_1_q[j] <= a[0][j];
      end
    end
  end

  // Stage 2: cofactors. Stage 3: determinant partial products, split at the
  // low E bits of each cofactor. Stage 4: determinant.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumEntries; k++) begin
        c2_q[k] <= CW'(p0_q[k]) - CW'(p1_q[k]);
        c3_q[k] <= c2_q[k];
        c4_q[k] <= c3_q[k];
      end
      a0_2_q <= a0_1_q;
      for (int j = 0; j < 3; j++) begin
        pl_q[j] <= a0_2_q[j] * $signed({1'b0, c2_q[3*j][E-1:0]});
        ph_q[j] <= a0_2_q[j] * $signed(c2_q[3*j][CW-1:E]);
      end
      det_q <= (DW'(ph_q[0]) <<< E) + DW'(pl_q[0])
             + (DW'(ph_q[1]) <<< E) + DW'(pl_q[1])
             + (DW'(ph_q[2]) <<< E) + DW'(pl_q[2]);
    end
  end

  assign dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);

  // Stage 5: rounded-division operands, signs and the singular test.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumEntries; k++) begin
        rem_q[k] <= (RW'(c4_q[k][CW-1] ? CW'(-c4_q[k]) : CW'(c4_q[k])) << (2*FRAC_BITS + 1))
                  + RW'(dmag);
        side_q.neg[k] <= c4_q[k][CW-1] ^ det_q[DW-1];
      end
      den_q           <= {dmag, 1'b0};
      side_q.singular <= dmag <= DW'(eps_i);
    end
  end

  assign valid_o = vld_q[4];
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

FILE: src/ninv_div_cell.sv
// ----------------------------------------------------------------------------
// ninv_div_cell: one restoring-division step for all nine entries
// Compares each partial remainder with the divisor shifted by this cell's
// weight, subtracts when it fits, sets that quotient bit and hands on.
// ----------------------------------------------------------------------------
module ninv_div_cell
  import ninv_pkg::*;
#(
  parameter int unsigned RW    = 134,
  parameter int unsigned DW    = 99,
  parameter int unsigned QW    = 34,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [RW-1:0] rem_i [NumEntries],
  input  logic [DW:0]   den_i,
  input  logic [QW-1:0] quo_i [NumEntries],
  input  ninv_side_t    side_i,
  output logic          valid_o,
  output logic [RW-1:0] rem_o [NumEntries],
  output logic [DW:0]   den_o,
  output logic [QW-1:0] quo_o [NumEntries],
  output ninv_side_t    side_o
);

  logic                 valid_q;
  logic [RW-1:0]        rem_q [NumEntries];
  logic [DW:0]          den_q;
  logic [QW-1:0]        quo_q [NumEntries];
  ninv_side_t           side_q;
  logic [RW-1:0]        dsh;

  assign dsh = RW'(den_i) << SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Compare and subtract in every lane.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumEntries; k++) begin
        if (rem_i[k] >= dsh) begin
          rem_q[k] <= rem_i[k] - dsh;
          quo_q[k] <= quo_i[k] | (QW'(1) << SHIFT);
        end else begin
          rem_q[k] <= rem_i[k];
          quo_q[k] <= quo_i[k];
        end
      end
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

FILE: src/normal_matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// normal_matrix_inverse_3x3: fixed-point inverse-transpose of a 3x3 matrix
// Determinant and adjugate computed exactly, then a chain of division cells
// gives each rounded, saturated entry of the normal matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* carries one world matrix per beat, nine signed
//   entries with FRAC_BITS fraction bits. Master stream m_axis_* returns one
//   normal matrix per beat; tuser flags singular and saturated results.
//   det_epsilon_we_i / det_epsilon_i write the singular threshold on |det|,
//   given with 3*FRAC_BITS fraction bits; write it only while idle.
// Pipeline: five cofactor/determinant stages, one division cell per quotient
//   bit plus one overflow cell, and the output register.
// Throughput: one beat per cycle. The whole pipeline advances together
//   whenever the output register is empty or being read.
// Stall: when the receiver holds m_axis_tready low with a beat pending, the
//   pipeline freezes and s_axis_tready drops; no beat is lost.
// Reset: all valid bits clear, the threshold returns to about 1e-6.
// ----------------------------------------------------------------------------
module normal_matrix_inverse_3x3
  import ninv_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // w_r0c0, w_r0c1, w_r0c2, w_r1c0, ... w_r2c2 from the lowest bits up
  input  logic [((NumEntries*ENTRY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // n_r0c0, n_r0c1, n_r0c2, n_r1c0, ... n_r2c2 from the lowest bits up
  output logic [((NumEntries*ENTRY_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular, saturated from the lowest bit up
  output logic [UserWidth-1:0]  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  det_epsilon_we_i,
  input  logic [EpsWidth-1:0]   det_epsilon_i
);

  localparam int unsigned E    = ENTRY_WIDTH;
  localparam int unsigned BW   = ((NumEntries*E+7)/8)*8;
  localparam int unsigned DW   = 3*E + 3;
  localparam int unsigned QB   = E + 1;
  localparam int unsigned QW   = QB + 1;
  localparam int unsigned NW0  = (2*E + 2*FRAC_BITS + 2 > DW) ? 2*E + 2*FRAC_BITS + 2 : DW;
  localparam int unsigned NW   = NW0 + 1;
  localparam int unsigned RW   = ((NW > DW + 1 + QB) ? NW : DW + 1 + QB) + 1;
  localparam int unsigned NC   = QB + 1;
  localparam logic [QB-1:0] LimNeg = QB'(1) << (E-1);
  localparam logic [QB-1:0] LimPos = LimNeg - 1'b1;
  localparam logic [E-1:0]  OneV   = (FRAC_BITS < E-1) ? E'(64'd1 << FRAC_BITS)
                                                       : {1'b0, {(E-1){1'b1}}};

  logic                  en;
  logic [EpsWidth-1:0]   eps_q;
  logic signed [E-1:0]   w [NumEntries];
  logic                  vld_s  [NC+1];
  logic [RW-1:0]         rem_s  [NC+1][NumEntries];
  logic [DW:0]           den_s  [NC+1];
  logic [QW-1:0]         quo_s  [NC+1][NumEntries];
  ninv_side_t            side_s [NC+1];
  logic [NumEntries*E-1:0] res_d;
  logic [NumEntries*E-1:0] res_q;
  logic                  sat_d;
  logic                  sat_q;
  logic                  sing_q;
  logic                  out_vld_q;

  // Global advance: the output register is free or being emptied.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (det_epsilon_we_i) begin
      eps_q <= det_epsilon_i;
    end
  end

  // Unpack the input beat.
  always_comb begin
    for (int k = 0; k < NumEntries; k++) begin
      w[k] = s_axis_tdata[k*E +: E];
    end
  end

  ninv_front #(
    .ENTRY_WIDTH (E),
    .FRAC_BITS   (FRAC_BITS),
    .RW          (RW),
    .DW          (DW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .w_i     (w),
    .eps_i   (eps_q),
    .valid_o (vld_s[0]),
    .rem_o   (rem_s[0]),
    .den_o   (den_s[0]),
    .side_o  (side_s[0])
  );

  always_comb begin
    for (int k = 0; k < NumEntries; k++) begin
      quo_s[0][k] = '0;
    end
  end

  // Division chain: the first cell detects quotients of 2^QB and more,
  // the rest produce quotient bits from the top down.
  for (genvar c = 0; c < NC; c++) begin : g_cell
    ninv_div_cell #(
      .RW    (RW),
      .DW    (DW),
      .QW    (QW),
      .SHIFT (QB - c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_s[c]),
      .rem_i   (rem_s[c]),
      .den_i   (den_s[c]),
      .quo_i   (quo_s[c]),
      .side_i  (side_s[c]),
      .valid_o (vld_s[c+1]),
      .rem_o   (rem_s[c+1]),
      .den_o   (den_s[c+1]),
      .quo_o   (quo_s[c+1]),
      .side_o  (side_s[c+1])
    );
  end

  // Saturate, apply sign, or substitute identity for a singular matrix.
  always_comb begin
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic          over;
    sat_d = 1'b0;
    res_d = '0;
    for (int k = 0; k < NumEntries; k++) begin
      lim  = side_s[NC].neg[k] ? LimNeg : LimPos;
      over = quo_s[NC][k][QB] || (quo_s[NC][k][QB-1:0] > lim);
      mag  = over ? lim : quo_s[NC][k][QB-1:0];
      sat_d = sat_d | over;
      if (side_s[NC].singular) begin
        res_d[k*E +: E] = (k % 4 == 0) ? OneV : '0;
      end else begin
        res_d[k*E +: E] = side_s[NC].neg[k] ? E'(-mag) : E'(mag);
      end
    end
    if (side_s[NC].singular) begin
      sat_d = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_s[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      sat_q  <= sat_d;
      sing_q <= side_s[NC].singular;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = BW'(res_q);
  always_comb begin
    m_axis_tuser                = '0;
    m_axis_tuser[UserSingular]  = sing_q;
    m_axis_tuser[UserSaturated] = sat_q;
  end

`ifndef NO_ASSERTIONS
  // A singular result never reports saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserSingular] |-> !m_axis_tuser[UserSaturated])
    else $error("singular result flagged saturated");

  // A singular result carries the identity diagonal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserSingular] |->
      (m_axis_tdata[0 +: E] == OneV) && (m_axis_tdata[4*E +: E] == OneV)
      && (m_axis_tdata[8*E +: E] == OneV) && (m_axis_tdata[E +: E] == '0))
    else $error("singular result is not identity");

  // The input only stalls while a result is held back by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for normal_matrix_inverse_3x3
// Drives world matrices on the slave stream and checks every normal matrix on
// the master stream against an exact wide-integer adjugate/determinant
// predictor, across several threshold settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import ninv_pkg::*;

  localparam int unsigned EW    = 32;
  localparam int unsigned FB    = 16;
  localparam int unsigned DW    = ((NumEntries * EW + 7) / 8) * 8;
  localparam int unsigned LAT   = EW + 8;
  localparam int          WDOG  = 3000;
  localparam int          HOLD  = 300;
  localparam int          PHASE_ITEMS = 240;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0]        uwide_t;

  typedef struct {
    logic [DW-1:0]        data;
    logic [UserWidth-1:0] user;
  } normal_beat_t;

  // Expected normal matrices, computed from each accepted world matrix.
  class normal_board;
    normal_beat_t    pending[$];
    logic [EpsWidth-1:0] eps;
    int errors, checked, n_singular, n_saturated;

    function new();
      eps = EpsReset;
    endfunction

    function wide_t cof(wide_t a, wide_t b, wide_t c, wide_t d);
      return a * b - c * d;
    endfunction

    // Exact inverse of A = transpose(W), rounded half away from zero.
    function normal_beat_t invert(logic [DW-1:0] w);
      normal_beat_t r;
      wide_t a[3][3];
      wide_t c[9];
      wide_t det;
      uwide_t dmag, num, q, lim, cmag;
      logic neg, sat;
      logic signed [EW-1:0] ent;
      sat = 1'b0;
      r.data = '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          ent = w[(j*3+i)*EW +: EW];
          a[i][j] = ent;
        end
      c[0] = cof(a[1][1], a[2][2], a[1][2], a[2][1]);
      c[1] = cof(a[0][2], a[2][1], a[0][1], a[2][2]);
      c[2] = cof(a[0][1], a[1][2], a[0][2], a[1][1]);
      c[3] = cof(a[1][2], a[2][0], a[1][0], a[2][2]);
      c[4] = cof(a[0][0], a[2][2], a[0][2], a[2][0]);
      c[5] = cof(a[0][2], a[1][0], a[0][0], a[1][2]);
      c[6] = cof(a[1][0], a[2][1], a[1][1], a[2][0]);
      c[7] = cof(a[0][1], a[2][0], a[0][0], a[2][1]);
      c[8] = cof(a[0][0], a[1][1], a[0][1], a[1][0]);
      det  = a[0][0] * c[0] + a[0][1] * c[3] + a[0][2] * c[6];
      dmag = det < 0 ? -det : det;
      // Near singular: identity, no saturation.
      if (dmag <= uwide_t'(eps)) begin
        for (int i = 0; i < 9; i++)
          r.data[i*EW +: EW] = (i % 4 == 0) ? EW'(1 << FB) : '0;
        r.user = '0;
        r.user[UserSingular] = 1'b1;
        return r;
      end
      for (int i = 0; i < 9; i++) begin
        neg  = (c[i] < 0) != (det < 0);
        cmag = c[i] < 0 ? -c[i] : c[i];
        num  = cmag << (2 * FB);
        q    = ((num << 1) + dmag) / (dmag << 1);
        lim  = (uwide_t'(1) << (EW - 1)) - uwide_t'(!neg);
        if (q > lim) begin
          q   = lim;
          sat = 1'b1;
        end
        r.data[i*EW +: EW] = neg ? EW'(-q) : EW'(q);
      end
      r.user = '0;
      r.user[UserSaturated] = sat;
      return r;
    endfunction

    function void note_input(logic [DW-1:0] w);
      pending.insert(pending.size(), invert(w));
    endfunction

    function void check_result(logic [DW-1:0] d, logic [UserWidth-1:0] u);
      normal_beat_t exp_b;
      logic bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result beat %h", d);
        return;
      end
      exp_b = pending.pop_front();
      checked++;
      n_singular  += u[UserSingular];
      n_saturated += u[UserSaturated];
      bad = 1'b0;
      for (int i = 0; i < 9; i++)
        if (d[i*EW +: EW] !== exp_b.data[i*EW +: EW]) begin
          bad = 1'b1;
          if (errors < 10)
            $display("ERROR: result %0d entry r%0dc%0d exp %h got %h", checked,
                     i / 3, i % 3, exp_b.data[i*EW +: EW], d[i*EW +: EW]);
        end
      if (u[UserSingular] !== exp_b.user[UserSingular]) begin
        bad = 1'b1;
        if (errors < 10)
          $display("ERROR: result %0d singular exp %b got %b", checked,
                   exp_b.user[UserSingular], u[UserSingular]);
      end
      if (u[UserSaturated] !== exp_b.user[UserSaturated]) begin
        bad = 1'b1;
        if (errors < 10)
          $display("ERROR: result %0d saturated exp %b got %b", checked,
                   exp_b.user[UserSaturated], u[UserSaturated]);
      end
      if (bad) errors++;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [DW-1:0]         s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DW-1:0]         m_tdata;
  logic [UserWidth-1:0]  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  eps_we = 1'b0;
  logic [EpsWidth-1:0]   eps_data = '0;

  normal_board board = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int sent           = 0;

  always #5 clk_i = ~clk_i;

  normal_matrix_inverse_3x3 #(.FRAC_BITS(FB), .ENTRY_WIDTH(EW)) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tdata     (s_tdata),
    .s_axis_tvalid    (s_tvalid),
    .s_axis_tready    (s_tready),
    .m_axis_tdata     (m_tdata),
    .m_axis_tuser     (m_tuser),
    .m_axis_tvalid    (m_tvalid),
    .m_axis_tready    (m_tready),
    .det_epsilon_we_i (eps_we),
    .det_epsilon_i    (eps_data)
  );

  // Result side: check beats, stall at random or during a long hold-off.
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || !rst_ni)
      quiet_cycles = 0;
    else if (++quiet_cycles >= WDOG) begin
      $display("ERROR: watchdog timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [EW-1:0] rand_entry(int kind);
    case (kind)
      0:       return $urandom;
      1:       return EW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return EW'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  function automatic logic [DW-1:0] diag(int d0, int d1, int d2);
    logic [DW-1:0] w;
    w = '0;
    w[0 +: EW]      = d0;
    w[4*EW +: EW]   = d1;
    w[8*EW +: EW]   = d2;
    return w;
  endfunction

  // Random matrix: mostly well-conditioned moderate values, plus full-range,
  // tiny (saturating) and rank-deficient ones.
  function automatic logic [DW-1:0] rand_matrix();
    logic [DW-1:0] w;
    int sel, kind;
    w = '0;
    sel = $urandom_range(99);
    kind = sel < 55 ? 1 : (sel < 75 ? 0 : 2);
    for (int i = 0; i < 9; i++) w[i*EW +: EW] = rand_entry(kind);
    if (sel >= 90)
      for (int c = 0; c < 3; c++)
        w[(6+c)*EW +: EW] = w[c*EW +: EW] + w[(3+c)*EW +: EW];
    return w;
  endfunction

  task automatic send_matrix(logic [DW-1:0] w);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk_i); while (!s_tready);
    board.note_input(w);
    sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= rand_matrix();
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Let the pipeline drain fully before touching the threshold.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_eps(logic [EpsWidth-1:0] v);
    eps_we   <= 1'b1;
    eps_data <= v;
    @(posedge clk_i);
    eps_we   <= 1'b0;
    board.eps = v;
  endtask

  initial begin
    logic [DW-1:0] w;
    logic [EpsWidth-1:0] eps_set[5];
    int idle_set[5], stall_set[5];
    eps_set   = '{EpsReset, '0, 40'd8, '1, '0};
    idle_set  = '{0, 82, 0, 26, 0};
    stall_set = '{0, 0, 82, 26, 0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) eps_set[4] = EpsWidth'({$urandom, $urandom});
      if (ph > 0) write_eps(eps_set[ph]);
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      if (ph == 0) begin
        // Directed: identity, zero, extremes, rounding, saturation, sign.
        send_matrix(diag(1 << FB, 1 << FB, 1 << FB));
        send_matrix('0);
        send_matrix(diag(2 << FB, 4 << FB, -(8 << FB)));
        send_matrix(diag(3 << FB, 3 << FB, 3 << FB));
        send_matrix(diag(3 << FB, 7 << FB, -(11 << FB)));
        send_matrix(diag(1, 1 << FB, 1 << FB));
        send_matrix(diag(-1, 1 << FB, 1 << FB));
        send_matrix(diag(2, 1 << FB, 1 << FB));
        send_matrix(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_matrix(diag(32'h80000000, 32'h80000000, 32'h80000000));
        send_matrix(diag(32'h80000000, 32'h7fffffff, 32'h80000000));
        send_matrix({NumEntries{32'h7fffffff}});
        send_matrix({NumEntries{32'h80000000}});
        send_matrix({NumEntries{32'hffffffff}});
        w = diag(1 << FB, 1 << FB, 1 << FB);
        w[1*EW +: EW] = 5 << FB;
        w[5*EW +: EW] = -(3 << FB);
        w[6*EW +: EW] = 7 << (FB - 1);
        send_matrix(w);
        send_matrix(diag(1 << 8, 1 << 8, 1 << 8));
        send_matrix(diag(1 << 6, 1 << 8, 1 << 8));
        send_matrix(diag(300, 1 << FB, 1 << FB));
      end
      if (ph == 2) begin
        // Threshold boundary: |det| equal to and one step above epsilon.
        send_matrix(diag(1, 2, 4));
        send_matrix(diag(-1, 2, 4));
        send_matrix(diag(1, 3, 3));
        send_matrix(diag(-1, 3, 3));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_req++;
        send_matrix(rand_matrix());
      end
      drain();
    end

    $display("Checked %0d normal matrices from %0d inputs over five threshold settings,",
             board.checked, sent);
    $display("  %0d singular and %0d saturated, with idle, stall and hold-off phases.",
             board.n_singular, board.n_saturated);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d, missing results: %0d", board.errors, board.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
